FILE: hdl/scam_pkg.sv
// ----------------------------------------------------------------------------
// Sound chip activity monitor package
// Shared types, codes and helper functions for the activity monitor.
// ----------------------------------------------------------------------------
package scam_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned TicksW   = 22;
  localparam int unsigned VolW     = 5;
  localparam int unsigned NumChips = 2;
  localparam int unsigned ChPerChip = 3;
  localparam int unsigned NumSlots = NumChips * ChPerChip;
  localparam int unsigned CfgIdxW  = 8;

  // Event kinds.
  typedef enum logic [2:0] {
    KindPsg0   = 3'd0,
    KindPsg1   = 3'd1,
    KindSpeech = 3'd2,
    KindDac    = 3'd3,
    KindFm     = 3'd4
  } kind_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgWindowTicks   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTicksPerSecond = 8'd1;

  localparam logic [TimeW-1:0]  WindowTicksReset    = 32'd20000000;
  localparam logic [TicksW-1:0] TicksPerSecondReset = 22'd2000000;

  // PSG volume registers and masks.
  localparam logic [7:0] VolRegFirst = 8'd8;
  localparam logic [7:0] VolRegLast  = 8'd10;
  localparam logic [7:0] VolMask     = 8'h1F;
  localparam logic [7:0] KeyMask     = 8'h78;
  localparam logic [TimeW-1:0] CountMax = '1;

  typedef struct packed {
    logic [31:0] event_time;
    logic [2:0]  event_kind;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_value;
  } evt_t;

  typedef struct packed {
    logic [2:0]  psg0_used_mask;
    logic [2:0]  psg1_used_mask;
    logic [7:0]  fm_used_mask;
    logic [31:0] dac_count;
    logic [31:0] speech_count;
    logic [31:0] end_time;
    logic        sustained;
    logic [31:0] max_silent_gap;
    logic [31:0] first_activity_time;
  } res_t;

  // View of the updated tracking state that the summary logic reduces.
  typedef struct packed {
    logic [NumSlots-1:0][VolW-1:0]      volume;
    logic [NumChips-1:0][ChPerChip-1:0] used;
    logic [NumSlots-1:0][TimeW-1:0]     last_off;
    logic [7:0]                         fm_keyed;
    logic [TimeW-1:0]                   fm_last_off;
    logic [TimeW-1:0]                   dac_events;
    logic [TimeW-1:0]                   last_dac;
    logic [TimeW-1:0]                   last_speech;
  } snap_t;

  function automatic logic [TimeW-1:0] max_time(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: hdl/scam_if.sv
// ----------------------------------------------------------------------------
// Activity monitor channel interfaces
// Event, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface scam_evt_if
  import scam_pkg::*;
();
  logic valid;
  logic ready;
  evt_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scam_res_if
  import scam_pkg::*;
();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scam_cfg_if
  import scam_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimeW-1:0]   wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: hdl/scam_summary.sv
// ----------------------------------------------------------------------------
// Activity monitor summary
// Reduces the updated tracking state to the end time and sustained flag.
// ----------------------------------------------------------------------------
module scam_summary
  import scam_pkg::*;
(
  input  snap_t              snap_i,
  input  logic [TimeW-1:0]   window_ticks_i,
  input  logic [TicksW-1:0]  ticks_per_second_i,
  output logic [TimeW-1:0]   end_time_o,
  output logic               sustained_o
);

  logic [NumSlots-1:0][TimeW-1:0] off_used;
  logic [NumSlots-1:0]            sounding;
  logic [TimeW-1:0]               m01, m23, m45, mchan, mdac, mtail;
  logic [TimeW-1:0]               half;
  logic                           dac_late;

  // An unused channel contributes nothing to the end time.
  always_comb begin
    for (int c = 0; c < NumChips; c++) begin
      for (int ch = 0; ch < ChPerChip; ch++) begin
        off_used[c*ChPerChip+ch] = snap_i.used[c][ch] ? snap_i.last_off[c*ChPerChip+ch] : '0;
        sounding[c*ChPerChip+ch] = snap_i.used[c][ch] &&
                                   (snap_i.volume[c*ChPerChip+ch] != '0);
      end
    end
  end

  // Balanced maximum tree over the nine candidate times.
  always_comb begin
    m01   = max_time(off_used[0], off_used[1]);
    m23   = max_time(off_used[2], off_used[3]);
    m45   = max_time(off_used[4], off_used[5]);
    mdac  = max_time(snap_i.last_dac, snap_i.last_speech);
    mchan = max_time(m01, m23);
    mtail = max_time(m45, max_time(mdac, snap_i.fm_last_off));
    end_time_o = max_time(mchan, mtail);
  end

  assign half     = {{(TimeW-TicksW+1){1'b0}}, ticks_per_second_i[TicksW-1:1]};
  assign dac_late = (snap_i.dac_events != '0) && (window_ticks_i >= half) &&
                    (snap_i.last_dac > (window_ticks_i - half));

  assign sustained_o = (|sounding) || (snap_i.fm_keyed != '0) || dac_late;

endmodule

FILE: hdl/sound_chip_activity_monitor_unit.sv
// ----------------------------------------------------------------------------
// Sound chip activity monitor
// Tracks PSG, speech, DAC and FM activity and reports a summary per event.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                               Handshake
//   evt_i    in         event_time, event_kind, reg_addr,     valid/ready
//                       reg_value
//   res_o    out        masks, counts, end time, sustained,   valid/ready
//                       max gap, first activity time
//   cfg_i    in         index, wdata                          valid/ready
//
// Each event beat is captured in the input register and is then applied to
// the tracking state, which also loads the result register. One beat per
// cycle is sustained while res_o accepts, since the input register refills
// in the cycle it drains. A stall on res_o holds the result register and
// then the input register; nothing is dropped. Reset (rst_ni low) clears all
// tracking state and restores the default configuration; the configuration
// port is always ready.
// ----------------------------------------------------------------------------
module sound_chip_activity_monitor_unit
  import scam_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  scam_evt_if.sink   evt_i,
  scam_res_if.source res_o,
  scam_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [TimeW-1:0]  window_q;
  logic [TicksW-1:0] tps_q;

  // Pipeline registers.
  logic in_valid_q, out_valid_q;
  evt_t evt_q;
  res_t res_q, res_d;
  logic advance;

  // Tracking state.
  logic [NumSlots-1:0][VolW-1:0]      vol_q, vol_d;
  logic [NumChips-1:0][ChPerChip-1:0] used_q, used_d;
  logic [NumSlots-1:0][TimeW-1:0]     off_q, off_d;
  logic [7:0]       fm_used_q, fm_used_d, fm_keyed_q, fm_keyed_d;
  logic [TimeW-1:0] fm_off_q, fm_off_d;
  logic [TimeW-1:0] dac_cnt_q, dac_cnt_d, sp_cnt_q, sp_cnt_d;
  logic [TimeW-1:0] dac_t_q, dac_t_d, sp_t_q, sp_t_d;
  logic [TimeW-1:0] prev_q, gap_q, gap_d, first_q, first_d;

  // Decoded event fields.
  logic [TimeW-1:0] t, gap;
  logic             held, is_vol, key_on, act;
  logic [1:0]       chan;
  logic [VolW-1:0]  vol;
  logic [7:0]       fm_bit;
  logic [TimeW-1:0] end_time;
  logic             sustained;
  snap_t            snap;

  // Configuration writes; indexes past the register list are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowTicksReset;
      tps_q    <= TicksPerSecondReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgWindowTicks) begin
        window_q <= cfg_i.wdata;
      end
      if (cfg_i.index == CfgTicksPerSecond) begin
        tps_q <= cfg_i.wdata[TicksW-1:0];
      end
    end
  end

  // The held event moves on whenever the result register is free or drains.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_i.ready) begin
        in_valid_q <= evt_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      evt_q <= evt_i.data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Field decode. Volume registers 8 to 10 map to channels A to C through
  // the low two address bits.
  always_comb begin
    t      = evt_q.event_time;
    is_vol = (evt_q.reg_addr >= VolRegFirst) && (evt_q.reg_addr <= VolRegLast);
    chan   = evt_q.reg_addr[1:0];
    vol    = VolW'(evt_q.reg_value & VolMask);
    key_on = (evt_q.reg_value & KeyMask) != '0;
    fm_bit = 8'(1) << evt_q.reg_value[2:0];
    held   = (fm_keyed_q != '0) || (vol_q != '0);
    gap    = t - prev_q;
    act    = ((evt_q.event_kind == KindPsg0 || evt_q.event_kind == KindPsg1) &&
              is_vol && (vol != '0)) ||
             (evt_q.event_kind == KindSpeech) || (evt_q.event_kind == KindDac) ||
             ((evt_q.event_kind == KindFm) && key_on);
  end

  // Next tracking state. The silent gap is judged on the state before this
  // event is applied.
  always_comb begin
    vol_d      = vol_q;
    used_d     = used_q;
    off_d      = off_q;
    fm_used_d  = fm_used_q;
    fm_keyed_d = fm_keyed_q;
    fm_off_d   = fm_off_q;
    dac_cnt_d  = dac_cnt_q;
    sp_cnt_d   = sp_cnt_q;
    dac_t_d    = dac_t_q;
    sp_t_d     = sp_t_q;
    gap_d      = gap_q;
    first_d    = first_q;

    if (!held && (prev_q != '0) && (first_q != '0) && (gap > gap_q)) begin
      gap_d = gap;
    end
    if (act && (first_q == '0)) begin
      first_d = t;
    end

    for (int c = 0; c < NumChips; c++) begin
      for (int ch = 0; ch < ChPerChip; ch++) begin
        if ((evt_q.event_kind == 3'(c)) && is_vol && (chan == 2'(ch))) begin
          if ((vol != '0) && (vol_q[c*ChPerChip+ch] == '0)) begin
            used_d[c][ch] = 1'b1;
          end
          if ((vol == '0) && (vol_q[c*ChPerChip+ch] != '0)) begin
            off_d[c*ChPerChip+ch] = t;
          end
          vol_d[c*ChPerChip+ch] = vol;
        end
      end
    end

    unique case (evt_q.event_kind)
      KindSpeech: begin
        if (sp_cnt_q != CountMax) begin
          sp_cnt_d = sp_cnt_q + 1'b1;
        end
        sp_t_d = t;
      end
      KindDac: begin
        if (dac_cnt_q != CountMax) begin
          dac_cnt_d = dac_cnt_q + 1'b1;
        end
        dac_t_d = t;
      end
      KindFm: begin
        if (key_on) begin
          fm_used_d  = fm_used_q | fm_bit;
          fm_keyed_d = fm_keyed_q | fm_bit;
        end else begin
          if ((fm_keyed_q & fm_bit) != '0) begin
            fm_off_d = t;
          end
          fm_keyed_d = fm_keyed_q & ~fm_bit;
        end
      end
      default: begin
        // PSG writes are handled above; unused kinds only move the gap.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q      <= '0;
      used_q     <= '0;
      off_q      <= '0;
      fm_used_q  <= '0;
      fm_keyed_q <= '0;
      fm_off_q   <= '0;
      dac_cnt_q  <= '0;
      sp_cnt_q   <= '0;
      dac_t_q    <= '0;
      sp_t_q     <= '0;
      prev_q     <= '0;
      gap_q      <= '0;
      first_q    <= '0;
    end else if (advance) begin
      vol_q      <= vol_d;
      used_q     <= used_d;
      off_q      <= off_d;
      fm_used_q  <= fm_used_d;
      fm_keyed_q <= fm_keyed_d;
      fm_off_q   <= fm_off_d;
      dac_cnt_q  <= dac_cnt_d;
      sp_cnt_q   <= sp_cnt_d;
      dac_t_q    <= dac_t_d;
      sp_t_q     <= sp_t_d;
      prev_q     <= t;
      gap_q      <= gap_d;
      first_q    <= first_d;
    end
  end

  // The summary is taken over the state as it stands after this event.
  always_comb begin
    snap.volume      = vol_d;
    snap.used        = used_d;
    snap.last_off    = off_d;
    snap.fm_keyed    = fm_keyed_d;
    snap.fm_last_off = fm_off_d;
    snap.dac_events  = dac_cnt_d;
    snap.last_dac    = dac_t_d;
    snap.last_speech = sp_t_d;
  end

  scam_summary u_summary (
    .snap_i             (snap),
    .window_ticks_i     (window_q),
    .ticks_per_second_i (tps_q),
    .end_time_o         (end_time),
    .sustained_o        (sustained)
  );

  always_comb begin
    res_d.psg0_used_mask      = used_d[0];
    res_d.psg1_used_mask      = used_d[1];
    res_d.fm_used_mask        = fm_used_d;
    res_d.dac_count           = dac_cnt_d;
    res_d.speech_count        = sp_cnt_d;
    res_d.end_time            = end_time;
    res_d.sustained           = sustained;
    res_d.max_silent_gap      = gap_d;
    res_d.first_activity_time = first_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

endmodule

FILE: hdl/scam_checker.sv
// ----------------------------------------------------------------------------
// Activity monitor checker
// Port-level checks on beat ordering and monotonic summary fields.
// ----------------------------------------------------------------------------
module scam_checker
  import scam_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic evt_valid_i,
  input logic evt_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input res_t res_data_i
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;
  logic       seen_q;
  logic [2:0] mask_q;
  logic [31:0] first_q;

  assign in_acc  = evt_valid_i && evt_ready_i;
  assign out_acc = res_valid_i && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      seen_q    <= 1'b0;
      mask_q    <= '0;
      first_q   <= '0;
    end else begin
      pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        seen_q  <= 1'b1;
        mask_q  <= res_data_i.psg0_used_mask;
        first_q <= res_data_i.first_activity_time;
      end
    end
  end

  // A result needs an event accepted at an earlier edge.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != '0)
    else $error("result beat without an outstanding event");

  // At most the input and result registers hold events.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more events in flight than register stages");

  // Used channels are never forgotten.
  a_mask_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> (res_data_i.psg0_used_mask & mask_q) == mask_q)
    else $error("PSG0 used mask lost a channel");

  // Once set, the first activity time never changes.
  a_first_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (first_q != '0) |-> res_data_i.first_activity_time == first_q)
    else $error("first activity time changed after it was set");

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("stalled result beat changed");

endmodule

bind sound_chip_activity_monitor_unit scam_checker u_scam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .evt_valid_i (evt_i.valid),
  .evt_ready_i (evt_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Sound chip activity monitor testbench
// Drives time-stamped sound-chip events through the unit and compares every
// summary beat with a cycle-free model of the tracking state.
// ----------------------------------------------------------------------------
module testbench;
  import scam_pkg::*;

  // Kinds 5 to 7 are not decoded by the unit; only the gap rule touches them.
  localparam logic [2:0] KindSpareLo = 3'd5;
  localparam logic [2:0] KindSpareHi = 3'd7;
  // Any configuration index above the defined ones must be ignored.
  localparam logic [CfgIdxW-1:0] CfgUnusedIndex = 8'd7;

  localparam int unsigned PhaseEvents = 350;
  localparam int unsigned NumPhases   = 5;
  localparam int unsigned MaxPause    = 18;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned MaxReports  = 10;

  logic clk_i;
  logic rst_ni;

  scam_evt_if evt_ch ();
  scam_res_if res_ch ();
  scam_cfg_if cfg_ch ();

  sound_chip_activity_monitor_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // Events waiting to be offered, and the summaries the unit owes us.
  evt_t pending_events[$];
  res_t expected_summaries[$];

  int unsigned error_count   = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served;
  int unsigned idle_cycles;
  int unsigned issued;
  logic [31:0] clock_now;
  bit          steady = 1'b0;

  // Model copy of the configuration registers.
  logic [TimeW-1:0]  window_len = WindowTicksReset;
  logic [TicksW-1:0] tick_rate  = TicksPerSecondReset;

  // Model copy of the tracking state; everything starts out cleared.
  logic [VolW-1:0]      chan_vol      [NumSlots]  = '{default: '0};
  logic [ChPerChip-1:0] chip_used     [NumChips]  = '{default: '0};
  logic [TimeW-1:0]     chan_off_time [NumSlots]  = '{default: '0};
  logic [7:0]           voices_used   = '0;
  logic [7:0]           voices_keyed  = '0;
  logic [TimeW-1:0]     voice_off_time = '0;
  logic [TimeW-1:0]     dac_seen       = '0;
  logic [TimeW-1:0]     speech_seen    = '0;
  logic [TimeW-1:0]     dac_time       = '0;
  logic [TimeW-1:0]     speech_time    = '0;
  logic [TimeW-1:0]     prior_time     = '0;
  logic [TimeW-1:0]     widest_gap     = '0;
  logic [TimeW-1:0]     first_sound    = '0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one event to the model state and returns the summary that the
  // unit must report for it.
  function automatic res_t apply_event(input evt_t e);
    res_t             r;
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] end_t;
    logic [TimeW-1:0] half_rate;
    logic [2:0]       kind;
    logic [VolW-1:0]  vol;
    logic [7:0]       voice_bit;
    logic             vol_reg;
    logic             held;
    logic             sounding;
    logic             sust;
    int               chan;
    int               slot;

    t       = e.event_time;
    kind    = e.event_kind;
    vol     = VolW'(e.reg_value & VolMask);
    vol_reg = (e.reg_addr >= VolRegFirst) && (e.reg_addr <= VolRegLast);

    // A silent gap only counts once something has sounded and nothing is
    // held at the moment the new event arrives.
    held = (voices_keyed != '0);
    for (int i = 0; i < NumSlots; i++) begin
      if (chan_vol[i] != '0) held = 1'b1;
    end
    if (!held && prior_time != '0 && first_sound != '0) begin
      if (t - prior_time > widest_gap) widest_gap = t - prior_time;
    end
    prior_time = t;

    sounding = ((kind == KindPsg0 || kind == KindPsg1) && vol_reg && vol != '0) ||
               kind == KindSpeech || kind == KindDac ||
               (kind == KindFm && (e.reg_value & KeyMask) != '0);
    if (sounding && first_sound == '0) first_sound = t;

    case (kind)
      KindPsg0, KindPsg1: begin
        if (vol_reg) begin
          chan = int'(e.reg_addr - VolRegFirst);
          slot = int'(kind) * ChPerChip + chan;
          if (vol != '0 && chan_vol[slot] == '0) chip_used[kind[0]][chan] = 1'b1;
          if (vol == '0 && chan_vol[slot] != '0) chan_off_time[slot] = t;
          chan_vol[slot] = vol;
        end
      end
      KindSpeech: begin
        if (speech_seen != CountMax) speech_seen = speech_seen + 1;
        speech_time = t;
      end
      KindDac: begin
        if (dac_seen != CountMax) dac_seen = dac_seen + 1;
        dac_time = t;
      end
      KindFm: begin
        voice_bit = 8'd1 << e.reg_value[2:0];
        if ((e.reg_value & KeyMask) != '0) begin
          voices_used  = voices_used | voice_bit;
          voices_keyed = voices_keyed | voice_bit;
        end else begin
          if ((voices_keyed & voice_bit) != '0) voice_off_time = t;
          voices_keyed = voices_keyed & ~voice_bit;
        end
      end
      default: ;
    endcase

    // Summary; PSG channels count toward it only once used.
    end_t = '0;
    sust  = 1'b0;
    for (int c = 0; c < NumChips; c++) begin
      for (int ch = 0; ch < ChPerChip; ch++) begin
        if (chip_used[c][ch]) begin
          if (chan_vol[c * ChPerChip + ch] != '0) sust = 1'b1;
          if (chan_off_time[c * ChPerChip + ch] > end_t) end_t = chan_off_time[c * ChPerChip + ch];
        end
      end
    end
    if (dac_time > end_t) end_t = dac_time;
    if (speech_time > end_t) end_t = speech_time;
    if (voice_off_time > end_t) end_t = voice_off_time;
    if (voices_keyed != '0) sust = 1'b1;
    // DAC tail: a sample in the last half second of the window keeps the
    // sound going; a window shorter than that half second never does.
    half_rate = TimeW'(tick_rate >> 1);
    if (dac_seen != '0 && window_len >= half_rate && dac_time > window_len - half_rate)
      sust = 1'b1;

    r.psg0_used_mask      = chip_used[0];
    r.psg1_used_mask      = chip_used[1];
    r.fm_used_mask        = voices_used;
    r.dac_count           = dac_seen;
    r.speech_count        = speech_seen;
    r.end_time            = end_t;
    r.sustained           = sust;
    r.max_silent_gap      = widest_gap;
    r.first_activity_time = first_sound;
    return r;
  endfunction

  // Idle draw for one beat; a steady stretch turns idling off on both sides.
  function automatic int unsigned pick_pause();
    if (steady) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, MaxPause) : 0;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("summary mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic check_summary(input res_t got);
    res_t want;
    if (expected_summaries.size() == 0) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("unexpected summary beat %h with no event outstanding", got);
    end else begin
      want = expected_summaries.pop_front();
      compare_field("psg0_used_mask", got.psg0_used_mask, want.psg0_used_mask);
      compare_field("psg1_used_mask", got.psg1_used_mask, want.psg1_used_mask);
      compare_field("fm_used_mask", got.fm_used_mask, want.fm_used_mask);
      compare_field("dac_count", got.dac_count, want.dac_count);
      compare_field("speech_count", got.speech_count, want.speech_count);
      compare_field("end_time", got.end_time, want.end_time);
      compare_field("sustained", got.sustained, want.sustained);
      compare_field("max_silent_gap", got.max_silent_gap, want.max_silent_gap);
      compare_field("first_activity_time", got.first_activity_time,
                    want.first_activity_time);
    end
  endtask

  // Event driver. The model is advanced at the edge on which a beat is
  // accepted, so expectations are queued strictly in acceptance order. The
  // next beat, or a gap, is decided with one assignment to valid per edge.
  int unsigned send_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_ch.valid <= 1'b0;
      evt_ch.data  <= '0;
      send_wait    <= 0;
    end else begin
      if (evt_ch.valid && evt_ch.ready)
        expected_summaries.push_back(apply_event(evt_ch.data));
      if (!evt_ch.valid || evt_ch.ready) begin
        if (send_wait != 0) begin
          evt_ch.valid <= 1'b0;
          send_wait    <= send_wait - 1;
        end else if (pending_events.size() != 0) begin
          evt_ch.valid <= 1'b1;
          evt_ch.data  <= pending_events.pop_front();
          send_wait    <= pick_pause();
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Summary monitor. After each accepted beat it drops ready for a drawn
  // number of cycles. On request it also holds ready low for a long
  // stretch so that the unit backs up and stalls its event input.
  int unsigned recv_wait;
  int unsigned hold_left;
  always @(posedge clk_i or negedge rst_ni) begin : summary_monitor
    int unsigned pause;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      recv_wait    <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else begin
      pause = recv_wait;
      if (res_ch.valid && res_ch.ready) begin
        check_summary(res_ch.data);
        pause = pick_pause();
      end else if (pause != 0) begin
        pause = pause - 1;
      end
      recv_wait <= pause;
      if (hold_requests != holds_served) begin
        holds_served <= holds_served + 1;
        hold_left    <= LongHold;
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= (pause == 0);
      end
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("sound_chip_activity_monitor_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_event(input logic [31:0] t, input logic [2:0] kind,
                             input logic [7:0] addr, input logic [7:0] value);
    pending_events.push_back('{event_time: t, event_kind: kind, reg_addr: addr,
                               reg_value: value});
    issued++;
  endtask

  // Configuration writes happen only with the unit drained.
  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [31:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.wdata <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (index == CfgWindowTicks) window_len = value;
    else if (index == CfgTicksPerSecond) tick_rate = value[TicksW-1:0];
  endtask

  // Waits for every owed summary, then keeps the clock running in case the unit
  // produces a stray beat after the last one.
  task automatic drain();
    while (pending_events.size() != 0 || evt_ch.valid || expected_summaries.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Turns every PSG channel and every FM voice off, which opens a silent gap.
  task automatic queue_silence();
    for (int s = 0; s < NumSlots; s++) begin
      clock_now = clock_now + $urandom_range(1, 200);
      queue_event(clock_now, (s < ChPerChip) ? KindPsg0 : KindPsg1,
                  VolRegFirst + 8'(s % ChPerChip), 8'($urandom_range(0, 255)) & ~VolMask);
    end
    for (int v = 0; v < 8; v++) begin
      clock_now = clock_now + $urandom_range(1, 200);
      queue_event(clock_now, KindFm, 8'($urandom_range(0, 255)),
                  (8'($urandom_range(0, 1)) << 7) | 8'(v));
    end
  endtask

  task automatic queue_random_event();
    logic [7:0]  addr;
    logic [7:0]  value;
    int unsigned pick;
    case ($urandom_range(0, 19))
      0:       clock_now = $urandom();
      1:       clock_now = clock_now + $urandom_range(0, 32'h7FFF_FFFF);
      2:       clock_now = clock_now - $urandom_range(0, 5000);
      default: clock_now = clock_now + $urandom_range(0, 3000);
    endcase
    addr  = 8'($urandom_range(0, 255));
    value = 8'($urandom_range(0, 255));
    pick  = $urandom_range(0, 99);
    if (pick < 40) begin
      // Mostly volume registers, a third of them writes of silence.
      if ($urandom_range(0, 4) != 0) addr = VolRegFirst + 8'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0) value = value & ~VolMask;
      queue_event(clock_now, ($urandom_range(0, 1) != 0) ? KindPsg1 : KindPsg0, addr, value);
    end else if (pick < 50) begin
      queue_event(clock_now, KindSpeech, addr, value);
    end else if (pick < 65) begin
      queue_event(clock_now, KindDac, addr, value);
    end else if (pick < 92) begin
      if ($urandom_range(0, 1) != 0) value = value & ~KeyMask;
      queue_event(clock_now, KindFm, addr, value);
    end else if (pick < 96) begin
      queue_event(clock_now, 3'($urandom_range(KindSpareLo, KindSpareHi)), addr, value);
    end else begin
      queue_silence();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    issued       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed events under the reset configuration.
    @(negedge clk_i);
    // A sound at time zero leaves the first activity time at zero.
    queue_event(32'd0, KindPsg0, 8'd8, 8'h1F);
    queue_event(32'd10, KindPsg0, 8'd8, 8'h00);
    queue_event(32'd50, KindPsg1, 8'd10, 8'hFF);
    // Volume bits clear with the upper bits set is an off write.
    queue_event(32'd60, KindPsg1, 8'd10, 8'hE0);
    queue_event(32'd5000, KindPsg0, 8'd9, 8'h01);
    queue_event(32'd5100, KindPsg0, 8'd9, 8'h02);
    // Addresses outside the volume registers only feed the gap rule.
    queue_event(32'd5200, KindPsg0, 8'd7, 8'h1F);
    queue_event(32'd5300, KindPsg1, 8'hFF, 8'hFF);
    queue_event(32'd5400, KindPsg0, 8'd9, 8'h00);
    queue_event(32'd6000, KindSpeech, 8'h00, 8'h00);
    queue_event(32'd7000, KindDac, 8'hFF, 8'hFF);
    queue_event(32'd8000, KindFm, 8'h00, 8'h7F);
    queue_event(32'd8100, KindFm, 8'h00, 8'h08);
    // Bit 7 alone does not key a voice on.
    queue_event(32'd8200, KindFm, 8'h00, 8'h87);
    queue_event(32'd8300, KindFm, 8'h00, 8'h80);
    queue_event(32'd8400, KindFm, 8'h00, 8'h05);
    for (int k = KindSpareLo; k <= KindSpareHi; k++)
      queue_event(32'd9000 + 32'(k), 3'(k), 8'hFF, 8'hFF);
    // A time stamp that runs backwards wraps the gap.
    queue_event(32'd100, KindPsg0, 8'd10, 8'h10);
    queue_event(32'd200, KindPsg0, 8'd10, 8'h00);
    queue_event(32'hFFFF_FFFF, KindDac, 8'h00, 8'h00);
    queue_event(32'd0, KindSpeech, 8'hFF, 8'hFF);
    queue_event(32'd30, KindPsg1, 8'd8, 8'h1F);
    queue_event(32'd40, KindPsg1, 8'd8, 8'h00);
    drain();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: clock_now = WindowTicksReset - 32'(TicksPerSecondReset >> 1) - 32'd100000;
        1: begin
          write_register(CfgWindowTicks, 32'd0);
          write_register(CfgTicksPerSecond, 32'd1);
          write_register(CfgUnusedIndex, $urandom());
          clock_now = $urandom();
        end
        2: begin
          write_register(CfgWindowTicks, 32'hFFFF_FFFF);
          write_register(CfgTicksPerSecond, 32'd4000000);
          clock_now = 32'hFFE0_0000;
        end
        3: begin
          // Window shorter than half a second: the DAC tail never holds.
          write_register(CfgWindowTicks, 32'd1000);
          steady = 1'b1;
          clock_now = 32'd0;
        end
        default: begin
          write_register(CfgWindowTicks, $urandom());
          write_register(CfgTicksPerSecond, 32'($urandom_range(1, 4000000)));
          steady = 1'b0;
          clock_now = window_len - 32'(tick_rate >> 1) - 32'd50000;
        end
      endcase
      @(negedge clk_i);
      // In the first phase the monitor stalls while the driver keeps going.
      if (phase == 0) hold_requests++;
      issued = 0;
      while (issued < PhaseEvents) queue_random_event();
      drain();
    end

    if (error_count == 0 && expected_summaries.size() == 0) begin
      $display("sound_chip_activity_monitor_unit verification clean");
    end else begin
      $display("sound_chip_activity_monitor_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/scam_pkg.sv
hdl/scam_if.sv
hdl/scam_summary.sv
hdl/sound_chip_activity_monitor_unit.sv
hdl/scam_checker.sv
verif/testbench.sv
